// ===== rtl/ecid_pkg.sv =====
// Package for the cut-based electron identification block.
// Holds candidate and result types, region limits and the working point cut table.
// No dependencies.
package ecid_pkg;

	// Field widths of one candidate
	localparam int unsigned ETA_W  = 15;
	localparam int unsigned DPHI_W = 15;
	localparam int unsigned VAR_W  = 16;
	localparam int unsigned HITS_W = 4;

	// Stream widths (tdata padded to whole bytes)
	localparam int unsigned IN_BITS     = ETA_W + DPHI_W + 6 * VAR_W + 1 + HITS_W;
	localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS    = 7;
	localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Eta region limits, LSB 1/4096
	localparam logic [ETA_W-1:0] ETA_BARREL   = 15'd6058;  // 1.479
	localparam logic [ETA_W-1:0] ETA_ENDCAP   = 15'd10240; // 2.5
	localparam logic [ETA_W-1:0] ETA_CRACK_LO = 15'd5915;  // 1.4442
	localparam logic [ETA_W-1:0] ETA_CRACK_HI = 15'd6414;  // 1.566

	// Working point codes
	localparam logic [1:0] WP_VETO   = 2'd0;
	localparam logic [1:0] WP_LOOSE  = 2'd1;
	localparam logic [1:0] WP_MEDIUM = 2'd2;
	localparam logic [1:0] WP_TIGHT  = 2'd3;

	// One candidate as it arrives
	typedef struct packed {
		logic [HITS_W-1:0]        lost_inner_hits;
		logic                     conversion_ok;
		logic signed [VAR_W-1:0]  inv_e_minus_inv_p;
		logic signed [VAR_W-1:0]  impact_dz;
		logic signed [VAR_W-1:0]  impact_d0;
		logic [VAR_W-1:0]         h_over_e;
		logic [VAR_W-1:0]         sigma_ieta_ieta;
		logic signed [DPHI_W-1:0] delta_phi_in;
		logic signed [VAR_W-1:0]  delta_eta_in;
		logic signed [ETA_W-1:0]  sc_eta;
	} cand_t;

	// One result, last field in the lowest bit
	typedef struct packed {
		logic pass_tight;
		logic pass_medium;
		logic pass_loose;
		logic pass_veto;
		logic in_crack;
		logic in_endcap;
		logic in_barrel;
	} result_t;

	// One cut set; thresholds are exclusive upper bounds on magnitudes, max_hits is inclusive
	typedef struct packed {
		logic [VAR_W-1:0]  deta;
		logic [DPHI_W-1:0] dphi;
		logic [VAR_W-1:0]  sihih;
		logic              hoe_en;
		logic [VAR_W-1:0]  hoe;
		logic [VAR_W-1:0]  d0;
		logic [VAR_W-1:0]  dz;
		logic              ooe_en;
		logic [VAR_W-1:0]  ooe;
		logic              hits_en;   // also enables the conversion cut
		logic [HITS_W-1:0] max_hits;
	} cut_t;

	// Indexed by {working point, endcap}
	localparam cut_t CUT_TABLE [8] = '{
		'{16'd459, 15'd3277,  16'd655, 1'b1, 16'd614, 16'd164, 16'd205, 1'b0, 16'd0,
			1'b0, 4'd0},
		'{16'd655, 15'd2867, 16'd1966, 1'b0,   16'd0, 16'd164, 16'd410, 1'b0, 16'd0,
			1'b0, 4'd0},
		'{16'd459,  15'd614,  16'd655, 1'b1, 16'd492,  16'd82, 16'd205, 1'b1, 16'd3277,
			1'b1, 4'd1},
		'{16'd590,  15'd410, 16'd1966, 1'b1, 16'd410,  16'd82, 16'd205, 1'b1, 16'd3277,
			1'b1, 4'd1},
		'{16'd262,  15'd246,  16'd655, 1'b1, 16'd492,  16'd82, 16'd102, 1'b1, 16'd3277,
			1'b1, 4'd1},
		'{16'd459,  15'd123, 16'd1966, 1'b1, 16'd410,  16'd82, 16'd102, 1'b1, 16'd3277,
			1'b1, 4'd1},
		'{16'd262,  15'd123,  16'd655, 1'b1, 16'd492,  16'd82, 16'd102, 1'b1, 16'd3277,
			1'b1, 4'd0},
		'{16'd328,   15'd82, 16'd1966, 1'b1, 16'd410,  16'd82, 16'd102, 1'b1, 16'd3277,
			1'b1, 4'd0}
	};

	// Magnitude of a 16-bit two's complement value; -32768 maps to 32768
	function automatic logic [VAR_W-1:0] mag16(input logic [VAR_W-1:0] v);
		return v[VAR_W-1] ? (~v + 1'b1) : v;
	endfunction

	// Magnitude of a 15-bit two's complement value
	function automatic logic [ETA_W-1:0] mag15(input logic [ETA_W-1:0] v);
		return v[ETA_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

// ===== rtl/electron_cut_based_id.sv =====
// Cut-based electron identification, top level with stream ports.
// Depends on ecid_pkg and ecid_cuts.
//
// Use: each request on the s_ channel carries one electron candidate's shower
// and track variables in fixed point. Each request on the m_ channel carries
// the region flags (barrel, endcap, crack) and the veto/loose/medium/tight
// pass bits for that candidate, in arrival order, one result per candidate.
// The candidate is registered on accept, the cuts are evaluated from the
// input register in pure logic and the result is registered in the result
// register, which drives m_tvalid. Throughput: one candidate per cycle while
// m_tready stays high, set by the two register stages each holding one request.
// Stall: when m_tready is low the result holds, the input stage still takes
// one more candidate if it is empty, then s_tready drops until the output drains.
// Reset: arst_n clears both stage valid bits; the data registers are not reset.
module electron_cut_based_id (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sc_eta, delta_eta_in, delta_phi_in, sigma_ieta_ieta, h_over_e, impact_d0,
	// impact_dz, inv_e_minus_inv_p, conversion_ok, lost_inner_hits, zero pad
	input  logic [ecid_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// in_barrel, in_endcap, in_crack, pass_veto, pass_loose, pass_medium,
	// pass_tight, zero pad
	output logic [ecid_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import ecid_pkg::*;

	logic    valid_s1;
	cand_t   cand_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_comb;
	logic    adv_s1;

	// Stage 1 moves on when the output register is free or draining
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cand_s1 <= cand_t'(s_tdata[IN_BITS-1:0]);
		end
	end

	ecid_cuts u_cuts (
		.cand (cand_s1),
		.res  (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, res_s2};

endmodule

// ===== rtl/ecid_cuts.sv =====
// Region flags and working point decisions for one candidate, pure logic.
// Depends on ecid_pkg (types, region limits, cut table).
module ecid_cuts (
	input  ecid_pkg::cand_t   cand,
	output ecid_pkg::result_t res
);
	import ecid_pkg::*;

	logic [ETA_W-1:0]  aeta;
	logic [VAR_W-1:0]  a_deta;
	logic [DPHI_W-1:0] a_dphi;
	logic [VAR_W-1:0]  a_d0;
	logic [VAR_W-1:0]  a_dz;
	logic [VAR_W-1:0]  a_ooe;
	logic              barrel;
	logic [3:0]        wp_pass;

	// Absolute values of the signed fields
	assign aeta   = mag15(cand.sc_eta);
	assign a_deta = mag16(cand.delta_eta_in);
	assign a_dphi = mag15(cand.delta_phi_in);
	assign a_d0   = mag16(cand.impact_d0);
	assign a_dz   = mag16(cand.impact_dz);
	assign a_ooe  = mag16(cand.inv_e_minus_inv_p);

	assign barrel = aeta < ETA_BARREL;

	// One cut set per working point, barrel or endcap chosen by eta
	always_comb begin
		cut_t c;
		for (int w = 0; w < 4; w++) begin
			c = CUT_TABLE[{w[1:0], ~barrel}];
			wp_pass[w] = (a_deta < c.deta) && (a_dphi < c.dphi)
				&& (cand.sigma_ieta_ieta < c.sihih)
				&& (!c.hoe_en || (cand.h_over_e < c.hoe))
				&& (a_d0 < c.d0) && (a_dz < c.dz)
				&& (!c.ooe_en || (a_ooe < c.ooe))
				&& (!c.hits_en || (cand.conversion_ok
					&& (cand.lost_inner_hits <= c.max_hits)));
		end
	end

	// Region flags and pass bits
	assign res.in_barrel   = barrel;
	assign res.in_endcap   = (aeta > ETA_BARREL) && (aeta < ETA_ENDCAP);
	assign res.in_crack    = (aeta > ETA_CRACK_LO) && (aeta < ETA_CRACK_HI);
	assign res.pass_veto   = wp_pass[WP_VETO];
	assign res.pass_loose  = wp_pass[WP_LOOSE];
	assign res.pass_medium = wp_pass[WP_MEDIUM];
	assign res.pass_tight  = wp_pass[WP_TIGHT];

endmodule

// ===== test/electron_cut_based_id_tb.sv =====
// Testbench for electron_cut_based_id: random and corner-case candidates go in over
// the input stream, and the flags that come out are checked against a local predictor.
// Depends on ecid_pkg and the electron_cut_based_id RTL.
module electron_cut_based_id_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ecid_pkg::*;

	// One candidate waiting to be sent, with the idle and stall rates of its phase
	typedef struct {
		cand_t cand;
		int    idle_pct;
		int    stall_pct;
	} pending_cand_t;

	// Exclusive magnitude limits of one cut set; a negative hoe, ooe or max_hits limit disables that cut
	typedef struct packed {
		int deta;
		int dphi;
		int sihih;
		int hoe;
		int d0;
		int dz;
		int ooe;
		int max_hits;
	} cut_lim_t;

	localparam int RAND_ITEMS = 700;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	pending_cand_t cand_queue[$];
	result_t       predicted_flags[$];
	int            stall_pct = 0;
	int            mismatches = 0;

	electron_cut_based_id DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Cut thresholds per working point, barrel or endcap set
	function automatic cut_lim_t wp_limits(input logic [1:0] wp, input bit endcap_set);
		case ({wp, endcap_set})
			{WP_VETO, 1'b0}:   return '{459, 3277,  655, 614, 164, 205,   -1, -1};
			{WP_VETO, 1'b1}:   return '{655, 2867, 1966,  -1, 164, 410,   -1, -1};
			{WP_LOOSE, 1'b0}:  return '{459,  614,  655, 492,  82, 205, 3277,  1};
			{WP_LOOSE, 1'b1}:  return '{590,  410, 1966, 410,  82, 205, 3277,  1};
			{WP_MEDIUM, 1'b0}: return '{262,  246,  655, 492,  82, 102, 3277,  1};
			{WP_MEDIUM, 1'b1}: return '{459,  123, 1966, 410,  82, 102, 3277,  1};
			{WP_TIGHT, 1'b0}:  return '{262,  123,  655, 492,  82, 102, 3277,  0};
			default:           return '{328,   82, 1966, 410,  82, 102, 3277,  0};
		endcase
	endfunction

	function automatic int mag_of(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// All cuts of one working point; every comparison strict except the hit count
	function automatic bit meets_wp(input cand_t c, input logic [1:0] wp, input bit endcap_set);
		cut_lim_t lim;
		int       eta_dev;
		int       phi_dev;
		lim = wp_limits(wp, endcap_set);
		eta_dev = c.delta_eta_in;
		phi_dev = c.delta_phi_in;
		if (mag_of(eta_dev) >= lim.deta) return 1'b0;
		if (mag_of(phi_dev) >= lim.dphi) return 1'b0;
		if (int'(c.sigma_ieta_ieta) >= lim.sihih) return 1'b0;
		if (lim.hoe >= 0 && int'(c.h_over_e) >= lim.hoe) return 1'b0;
		if (mag_of(int'(c.impact_d0)) >= lim.d0) return 1'b0;
		if (mag_of(int'(c.impact_dz)) >= lim.dz) return 1'b0;
		if (lim.ooe >= 0 && mag_of(int'(c.inv_e_minus_inv_p)) >= lim.ooe) return 1'b0;
		if (lim.max_hits >= 0) begin
			if (!c.conversion_ok) return 1'b0;
			if (int'(c.lost_inner_hits) > lim.max_hits) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Region flags and working point decisions for one candidate
	function automatic result_t classify_candidate(input cand_t c);
		result_t r;
		int      eta;
		int      aeta;
		bit      endcap_set;
		eta = c.sc_eta;
		aeta = mag_of(eta);
		r.in_barrel = (aeta < 6058);
		r.in_endcap = (aeta > 6058) && (aeta < 10240);
		r.in_crack = (aeta > 5915) && (aeta < 6414);
		// exactly at the barrel limit and beyond the endcap still use the endcap cuts
		endcap_set = !r.in_barrel;
		r.pass_veto = meets_wp(c, WP_VETO, endcap_set);
		r.pass_loose = meets_wp(c, WP_LOOSE, endcap_set);
		r.pass_medium = meets_wp(c, WP_MEDIUM, endcap_set);
		r.pass_tight = meets_wp(c, WP_TIGHT, endcap_set);
		return r;
	endfunction

	// Clean candidate: central, perfect match, passes everything
	function automatic cand_t nominal_cand();
		cand_t c;
		c = '0;
		c.conversion_ok = 1'b1;
		return c;
	endfunction

	// Mostly inside the limit, some right on it, some anywhere up to four times it
	function automatic int near_limit(input int lim);
		int sel;
		int top;
		sel = $urandom_range(99);
		top = (lim <= 0) ? 4096 : lim;
		if (sel < 70)
			return $urandom_range(top - 1);
		else if (sel < 85)
			return top - 1 + $urandom_range(2);
		return $urandom_range(4 * top);
	endfunction

	function automatic int with_sign(input int v);
		return ($urandom_range(1) != 0) ? -v : v;
	endfunction

	// Candidate aimed at one working point and region, or pure noise
	function automatic cand_t random_cand();
		cand_t        c;
		logic [159:0] noise;
		cut_lim_t     lim;
		logic [1:0]   wp;
		bit           endcap_set;
		int           eta;
		int           sel;
		noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		if ($urandom_range(9) < 2) begin
			c = noise[IN_BITS-1:0];
			return c;
		end
		wp = 2'($urandom_range(3));
		endcap_set = ($urandom_range(1) != 0);
		lim = wp_limits(wp, endcap_set);
		sel = $urandom_range(3);
		if (endcap_set) begin
			if (sel == 0) begin
				case ($urandom_range(4))
					0: eta = 6058;
					1: eta = 10239;
					2: eta = 10240;
					3: eta = 16384;
					default: eta = 6413;
				endcase
			end else begin
				eta = $urandom_range(16383, 6058);
			end
		end else begin
			if (sel == 0) begin
				case ($urandom_range(3))
					0: eta = 0;
					1: eta = 5915;
					2: eta = 5916;
					default: eta = 6057;
				endcase
			end else begin
				eta = $urandom_range(6057);
			end
		end
		c.sc_eta = 15'(with_sign(eta));
		c.delta_eta_in = 16'(with_sign(near_limit(lim.deta)));
		c.delta_phi_in = 15'(with_sign(near_limit(lim.dphi)));
		c.sigma_ieta_ieta = 16'(near_limit(lim.sihih));
		c.h_over_e = 16'(near_limit(lim.hoe));
		c.impact_d0 = 16'(with_sign(near_limit(lim.d0)));
		c.impact_dz = 16'(with_sign(near_limit(lim.dz)));
		c.inv_e_minus_inv_p = 16'(with_sign(near_limit(lim.ooe)));
		c.conversion_ok = ($urandom_range(9) != 0);
		sel = $urandom_range(9);
		if (sel < 6)
			c.lost_inner_hits = '0;
		else if (sel < 8)
			c.lost_inner_hits = 4'd1;
		else
			c.lost_inner_hits = 4'($urandom_range(15));
		return c;
	endfunction

	task automatic queue_cand(input cand_t c, input int idle_pct, input int stall_pct_in);
		pending_cand_t p;
		p.cand = c;
		p.idle_pct = idle_pct;
		p.stall_pct = stall_pct_in;
		cand_queue.push_back(p);
	endtask

	// Compare one accepted result with the oldest prediction
	task automatic check_result(input result_t got);
		result_t want;
		if (predicted_flags.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %b arrived with no candidate pending", $time, got);
			return;
		end
		want = predicted_flags.pop_front();
		if (want.in_barrel !== got.in_barrel || want.in_endcap !== got.in_endcap ||
			want.in_crack !== got.in_crack || want.pass_veto !== got.pass_veto ||
			want.pass_loose !== got.pass_loose || want.pass_medium !== got.pass_medium ||
			want.pass_tight !== got.pass_tight) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: flags (tight..barrel) expected %b got %b",
					$time, want, got);
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: send queued candidates, predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predicted_flags.push_back(classify_candidate(cand_t'(s_tdata[IN_BITS-1:0])));
			if (!s_tvalid || s_tready) begin
				if (cand_queue.size() != 0 && $urandom_range(99) >= cand_queue[0].idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_TDATA_W'(cand_queue[0].cand);
					stall_pct <= cand_queue[0].stall_pct;
					cand_queue.delete(0);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check accepted results, stall the output at the phase's rate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(result_t'(m_tdata[OUT_BITS-1:0]));
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Stimulus and end of run
	initial begin
		cand_t c;
		int    eta_pts[13];
		int    idle_pct;
		int    stall_rate;
		eta_pts = '{0, -16384, 16383, 6057, 6058, 6059, -6058, 10239, 10240,
			5915, 5916, 6413, 6414};

		// region edges, crack edges and eta extremes
		foreach (eta_pts[i]) begin
			c = nominal_cand();
			c.sc_eta = 15'(eta_pts[i]);
			queue_cand(c, 0, 0);
		end
		// field extremes, one at a time
		c = nominal_cand(); c.delta_eta_in = 16'sh8000; queue_cand(c, 0, 0);
		c = nominal_cand(); c.delta_phi_in = 15'sh4000; queue_cand(c, 0, 0);
		c = nominal_cand(); c.sigma_ieta_ieta = 16'hffff; queue_cand(c, 0, 0);
		// endcap veto ignores H/E
		c = nominal_cand(); c.sc_eta = 15'sd8000; c.h_over_e = 16'hffff; queue_cand(c, 0, 0);
		c = nominal_cand(); c.impact_d0 = 16'sh7fff; queue_cand(c, 0, 0);
		c = nominal_cand(); c.impact_dz = 16'sh8000; queue_cand(c, 0, 0);
		// veto has no 1/E-1/p cut
		c = nominal_cand(); c.inv_e_minus_inv_p = 16'sh8000; queue_cand(c, 0, 0);
		// conversion failure only stops the points with a hit cut
		c = nominal_cand(); c.conversion_ok = 1'b0; queue_cand(c, 0, 0);
		c = nominal_cand(); c.lost_inner_hits = 4'd1; queue_cand(c, 0, 0);
		c = nominal_cand(); c.lost_inner_hits = 4'd15; queue_cand(c, 0, 0);
		// strict compare right at a threshold and one below it
		c = nominal_cand(); c.delta_eta_in = 16'sd262; queue_cand(c, 0, 0);
		c = nominal_cand(); c.delta_eta_in = -16'sd261; queue_cand(c, 0, 0);

		// random part in four flow-control phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_rate = 0; end
				1: begin idle_pct = 66; stall_rate = 0; end
				2: begin idle_pct = 0; stall_rate = 66; end
				default: begin idle_pct = 30; stall_rate = 30; end
			endcase
			for (int n = 0; n < RAND_ITEMS / 4; n++)
				queue_cand(random_cand(), idle_pct, stall_rate);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// sample at the falling edge so the driver's updates have settled
		while (cand_queue.size() != 0 || s_tvalid)
			@(negedge clk);
		while (predicted_flags.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hang guard
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
